### rtl/core/str_pkg.sv
// Package for the stepper trapezoid ramp generator.
// Holds the sequencer state type and fixed codes; used by all modules.
`timescale 1ns / 1ps
package str_pkg;
  localparam logic [19:0] PeriodMax = 20'hFFFFF;

  // Configuration register indexes.
  localparam logic CfgMinPeriod = 1'b0;
  localparam logic CfgMaxPeriod = 1'b1;

  // Input transaction kinds.
  localparam logic ModeStart = 1'b0;
  localparam logic ModeTick = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_DIV,
    ST_START_SQRT,
    ST_START_FIN,
    ST_RAMP_DIV,
    ST_RAMP_FIN,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;
endpackage

### rtl/core/str_divider.sv
// Shared restoring divider, one quotient bit per cycle, 64 by 64 bits.
// Depends on str_pkg for the request struct.
`timescale 1ns / 1ps
module str_divider import str_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        busy_o,
  output logic [63:0] quot_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.num;
      den_d = req_i.den;
      cnt_d = 7'd64;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 7'd1;
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = req_i.start || (cnt_q != '0);
  assign quot_o = quo_q;
endmodule

### rtl/core/str_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on str_pkg only by convention of the project.
`timescale 1ns / 1ps
module str_isqrt import str_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        busy_o,
  output logic [31:0] root_o
);
  logic [63:0] v_q, v_d, res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic        run_q, run_d;
  logic [63:0] sum;

  always_comb begin
    v_d = v_q;
    res_d = res_q;
    bit_d = bit_q;
    run_d = run_q;
    sum = res_q + bit_q;
    if (start_i) begin
      v_d = val_i;
      res_d = '0;
      bit_d = 64'h4000_0000_0000_0000;
      run_d = 1'b1;
    end else if (run_q) begin
      if (bit_q == '0) begin
        run_d = 1'b0;
      end else begin
        if (v_q >= sum) begin
          v_d = v_q - sum;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign busy_o = start_i || run_q;
  assign root_o = res_q[31:0];
endmodule

### rtl/core/stepper_trapezoid_ramp.sv
// Top level of the stepper trapezoid ramp generator: sequencer and state.
// Depends on str_pkg, str_divider and str_isqrt.
//
//   channel  | handshake          | payload
//   input    | in_valid_i/stall_o | mode, move_steps, top_speed, acceleration
//   output   | out_valid_o/stall_i| accepted .. position
//   config   | cfg_we_i           | cfg_index_i, cfg_data_i
//
// A start runs two 64-bit divides and a 32-step square root, a step tick that
// updates the ramp runs one divide, and other ticks run neither; the shared
// divider yields one quotient bit per cycle.
// Reset clears all move state; the registers return to 9 and 65000.
// Input stall is high while an item is in work or its result waits.
`timescale 1ns / 1ps
module stepper_trapezoid_ramp import str_pkg::*; #(
  parameter int unsigned TIMER_HZ = 1000000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic signed [31:0] move_steps_i,
  input  logic [19:0]        top_speed_i,
  input  logic [23:0]        acceleration_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic               direction_o,
  output logic               step_level_o,
  output logic [19:0]        reload_period_o,
  output logic               running_o,
  output logic               move_done_o,
  output logic signed [31:0] position_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  localparam logic [63:0] Hz2 = 64'(TIMER_HZ) * 64'(TIMER_HZ);
  localparam logic [63:0] KConst = (Hz2 / 64'd1000000) * 64'd913952
                                 + ((Hz2 % 64'd1000000) * 64'd913952) / 64'd1000000;

  seq_state_e  state_q, state_d;
  logic [15:0] min_q, max_q;
  logic [31:0] steps_left_q, ramp_q, brake_q, alen_q, pos_q;
  logic [19:0] period_q;
  logic [15:0] cruise_q;
  logic        cruising_q, braking_q, active_q, pulse_q, neg_q;
  logic        acc_q, done_q;
  logic [19:0] speed_q;

  div_req_t    dreq;
  logic        dbusy, sbusy, sstart;
  logic [63:0] dquot;
  logic [31:0] sroot;

  str_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .busy_o(dbusy), .quot_o(dquot));
  str_isqrt u_sqrt (.clk_i, .rst_ni, .start_i(sstart), .val_i(dquot),
                    .busy_o(sbusy), .root_o(sroot));

  logic        take;
  logic        start_ok;
  logic [31:0] sl_dec, need;
  logic [31:0] brake_dec, ramp_inc;
  logic        tick_step;

  assign take = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign start_ok = !active_q && move_steps_i != 0 && top_speed_i != '0
                    && acceleration_i != '0;
  assign sl_dec = steps_left_q - 32'd1;
  assign need = (cruising_q ? alen_q : ramp_q) == '0 ? 32'd1
                : (cruising_q ? alen_q : ramp_q);
  assign brake_dec = brake_q - 32'd1;
  assign ramp_inc = ramp_q + 32'd1;
  assign tick_step = active_q && pulse_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (mode_i == ModeStart) state_d = start_ok ? ST_START_DIV : ST_OUT;
          else if (tick_step && steps_left_q > 32'd1) state_d = ST_RAMP_DIV;
          else state_d = ST_OUT;
        end
      end
      ST_START_DIV:  if (!dbusy) state_d = ST_START_SQRT;
      ST_START_SQRT: if (!sbusy) state_d = ST_START_FIN;
      ST_START_FIN:  if (!dbusy) state_d = ST_OUT;
      ST_RAMP_DIV:   if (!dbusy) state_d = ST_RAMP_FIN;
      ST_RAMP_FIN:   state_d = ST_OUT;
      ST_OUT:        if (!out_stall_i) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // The start quotient TIMER_HZ/speed is issued after the square root finishes,
  // since both divides share one unit.
  logic        div_started_q;
  logic        need_brake;
  logic        brk_now;
  assign need_brake = !braking_q && (sl_dec <= need);
  assign brk_now = braking_q || need_brake;

  always_comb begin
    dreq = '{start: 1'b0, num: '0, den: 64'd1};
    sstart = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (take && mode_i == ModeStart && start_ok) begin
          dreq.start = 1'b1;
          dreq.num = KConst;
          dreq.den = {40'd0, acceleration_i};
        end else if (take && mode_i == ModeTick && tick_step && steps_left_q > 32'd1) begin
          dreq.start = 1'b1;
          dreq.num = {43'd0, period_q, 1'b0};
          if (brk_now) dreq.den = {30'd0, (need_brake ? need : brake_q) - 32'd1, 2'b01};
          else dreq.den = {30'd0, ramp_inc, 2'b01};
        end
      end
      ST_START_DIV: sstart = !dbusy;
      ST_START_SQRT: begin
        if (!sbusy && !div_started_q) begin
          dreq.start = 1'b1;
          dreq.num = 64'(TIMER_HZ);
          dreq.den = {44'd0, speed_q};
        end
      end
      default: ;
    endcase
  end

  logic [63:0] psum;
  logic [63:0] pdif;
  logic [63:0] cp;
  assign psum = {44'd0, period_q} + dquot;
  assign pdif = {44'd0, period_q} - dquot;
  always_comb begin
    cp = dquot;
    if (cp < {48'd0, min_q}) cp = {48'd0, min_q};
    if (cp > {48'd0, max_q}) cp = {48'd0, max_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      min_q <= 16'd9;
      max_q <= 16'd65000;
      steps_left_q <= '0; period_q <= '0; cruise_q <= '0;
      ramp_q <= '0; brake_q <= '0; alen_q <= '0; pos_q <= '0;
      cruising_q <= 1'b0; braking_q <= 1'b0; active_q <= 1'b0;
      pulse_q <= 1'b0; neg_q <= 1'b0; acc_q <= 1'b0; done_q <= 1'b0;
      div_started_q <= 1'b0;
      speed_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CfgMinPeriod) min_q <= cfg_data_i;
        else max_q <= cfg_data_i;
      end
      case (state_q)
        ST_IDLE: begin
          div_started_q <= 1'b0;
          if (take) begin
            acc_q <= 1'b0;
            done_q <= 1'b0;
            if (mode_i == ModeStart) begin
              if (start_ok) begin
                acc_q <= 1'b1;
                neg_q <= move_steps_i[31];
                steps_left_q <= move_steps_i[31] ? 32'd0 - move_steps_i : move_steps_i;
                ramp_q <= '0; brake_q <= '0; alen_q <= '0;
                cruising_q <= 1'b0; braking_q <= 1'b0; pulse_q <= 1'b0;
                active_q <= 1'b1;
                // The speed is needed after the input has moved on.
                speed_q <= top_speed_i;
              end
            end else if (active_q) begin
              pulse_q <= !pulse_q;
              if (pulse_q) begin
                pos_q <= pos_q + (neg_q ? 32'hFFFF_FFFF : 32'd1);
                if (steps_left_q <= 32'd1) begin
                  steps_left_q <= '0;
                  active_q <= 1'b0;
                  done_q <= 1'b1;
                end else begin
                  steps_left_q <= sl_dec;
                  if (need_brake) begin
                    braking_q <= 1'b1;
                    brake_q <= need;
                  end
                  if (!brk_now && !cruising_q) ramp_q <= ramp_inc;
                end
              end
            end
          end
        end
        ST_START_SQRT: begin
          if (!sbusy && !div_started_q) begin
            div_started_q <= 1'b1;
            period_q <= (sroot > 32'(PeriodMax)) ? PeriodMax : sroot[19:0];
          end
        end
        ST_START_FIN: if (!dbusy) cruise_q <= cp[15:0];
        ST_RAMP_FIN: begin
          if (braking_q) begin
            if (brake_q > 32'd1) begin
              brake_q <= brake_dec;
              period_q <= (psum > {48'd0, max_q}) ? {4'd0, max_q} : psum[19:0];
            end
          end else if (!cruising_q) begin
            if (pdif <= {48'd0, cruise_q}) begin
              period_q <= {4'd0, cruise_q};
              cruising_q <= 1'b1;
              alen_q <= ramp_q;
            end else begin
              period_q <= pdif[19:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign accepted_o = acc_q;
  assign direction_o = !neg_q;
  assign step_level_o = pulse_q;
  assign reload_period_o = period_q;
  assign running_o = active_q;
  assign move_done_o = done_q;
  assign position_o = pos_q;
endmodule

### test/stepper_trapezoid_ramp_test.sv
// Self-checking testbench for the stepper trapezoid ramp generator.
// Depends on str_pkg and stepper_trapezoid_ramp; predicts every result in SystemVerilog.
`timescale 1ns / 1ps
module stepper_trapezoid_ramp_test;
  import str_pkg::*;

  localparam int unsigned TimerHz = 1000000;

  typedef struct {
    logic        mode;
    logic [31:0] steps;
    logic [19:0] speed;
    logic [23:0] accel;
  } motion_cmd_t;

  typedef struct {
    logic        accepted;
    logic        direction;
    logic        step_level;
    logic [19:0] reload;
    logic        running;
    logic        done;
    logic [31:0] position;
  } pin_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd_mode = 1'b0;
  logic signed [31:0] cmd_steps = '0;
  logic [19:0] cmd_speed = '0;
  logic [23:0] cmd_accel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic accepted, direction, step_level, running, move_done;
  logic [19:0] reload_period;
  logic signed [31:0] position;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  motion_cmd_t pending_cmds[$];
  pin_state_t expected_pins[$];
  int unsigned mismatches = 0;
  int unsigned accept_count = 0;
  int unsigned present_count = 0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  bit quiet = 1'b0;

  // Predicted block state.
  logic [31:0] m_min_period, m_max_period;
  logic [31:0] m_steps_left, m_period, m_cruise, m_ramp_n, m_brake_n, m_accel_len;
  logic [31:0] m_position;
  logic m_cruising, m_braking, m_active, m_pulse, m_negative;

  stepper_trapezoid_ramp uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(cmd_mode), .move_steps_i(cmd_steps),
    .top_speed_i(cmd_speed), .acceleration_i(cmd_accel),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .accepted_o(accepted), .direction_o(direction), .step_level_o(step_level),
    .reload_period_o(reload_period), .running_o(running),
    .move_done_o(move_done), .position_o(position),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [19:0] launch_period(logic [23:0] acc);
    logic [63:0] hz2, k, c;
    hz2 = 64'(TimerHz) * 64'(TimerHz);
    k = (hz2 / 1000000) * 913952 + ((hz2 % 1000000) * 913952) / 1000000;
    c = root64(k / 64'(acc));
    return (c > 64'hFFFFF) ? 20'hFFFFF : c[19:0];
  endfunction

  task automatic reset_model();
    m_min_period = 9;
    m_max_period = 65000;
    {m_steps_left, m_period, m_cruise, m_ramp_n, m_brake_n, m_accel_len} = '0;
    m_position = '0;
    {m_cruising, m_braking, m_active, m_pulse, m_negative} = '0;
  endtask

  // Advances the predicted state by one transaction and returns the expected pins.
  task automatic advance_ramp(input motion_cmd_t c, output pin_state_t r);
    logic [63:0] p, cp;
    logic [31:0] need;
    logic ok, fin;
    ok = 1'b0;
    fin = 1'b0;
    if (c.mode == ModeStart) begin
      if (!m_active && c.steps != 0 && c.speed != 0 && c.accel != 0) begin
        cp = 64'(TimerHz) / 64'(c.speed);
        m_negative = c.steps[31];
        m_steps_left = m_negative ? -c.steps : c.steps;
        if (cp < 64'(m_min_period)) cp = 64'(m_min_period);
        if (cp > 64'(m_max_period)) cp = 64'(m_max_period);
        m_cruise = cp[31:0];
        {m_ramp_n, m_brake_n, m_accel_len} = '0;
        {m_cruising, m_braking, m_pulse} = '0;
        m_period = 32'(launch_period(c.accel));
        m_active = 1'b1;
        ok = 1'b1;
      end
    end else if (m_active) begin
      m_pulse = !m_pulse;
      // A full step completes on the falling edge of the step pin.
      if (!m_pulse) begin
        m_position = m_negative ? m_position - 1 : m_position + 1;
        if (m_steps_left <= 1) begin
          m_steps_left = 0;
          m_active = 1'b0;
          fin = 1'b1;
        end else begin
          m_steps_left = m_steps_left - 1;
          if (!m_braking) begin
            need = m_cruising ? m_accel_len : m_ramp_n;
            if (need == 0) need = 1;
            if (m_steps_left <= need) begin
              m_braking = 1'b1;
              m_brake_n = need;
            end
          end
          if (!m_braking) begin
            if (!m_cruising) begin
              p = 64'(m_period);
              m_ramp_n = m_ramp_n + 1;
              p = p - (2 * p) / (4 * 64'(m_ramp_n) + 1);
              if (p <= 64'(m_cruise)) begin
                p = 64'(m_cruise);
                m_cruising = 1'b1;
                m_accel_len = m_ramp_n;
              end
              m_period = p[31:0];
            end
          end else if (m_brake_n > 1) begin
            p = 64'(m_period);
            m_brake_n = m_brake_n - 1;
            p = p + (2 * p) / (4 * 64'(m_brake_n) + 1);
            if (p > 64'(m_max_period)) p = 64'(m_max_period);
            m_period = p[31:0];
          end
        end
      end
    end
    r.accepted = ok;
    r.direction = !m_negative;
    r.step_level = m_pulse;
    r.reload = m_period[19:0];
    r.running = m_active;
    r.done = fin;
    r.position = m_position;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic add_start(input logic [31:0] s, input logic [19:0] v, input logic [23:0] a);
    motion_cmd_t c;
    c.mode = ModeStart;
    c.steps = s;
    c.speed = v;
    c.accel = a;
    pending_cmds.push_back(c);
  endtask

  task automatic add_ticks(input int unsigned n);
    motion_cmd_t c;
    repeat (n) begin
      c.mode = ModeTick;
      c.steps = $urandom;
      c.speed = 20'($urandom);
      c.accel = 24'($urandom);
      pending_cmds.push_back(c);
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_pins.size() != 0)
      @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgMinPeriod) m_min_period = 32'(val);
    else m_max_period = 32'(val);
  endtask

  // One move with random content, ticked to its end or past it; sometimes a start lands mid-move.
  task automatic add_random_move(output int unsigned n);
    int unsigned len, t;
    logic [19:0] v;
    len = $urandom_range(1, 40);
    v = ($urandom_range(0, 1) == 1) ? 20'($urandom) : 20'($urandom_range(1, 3000));
    if (v == 0) v = 1;
    add_start($urandom_range(0, 1) ? -32'(len) : 32'(len), v,
              ($urandom_range(0, 1) == 1) ? 24'($urandom_range(1, 16777215))
                                          : 24'($urandom_range(1, 20000)));
    t = 2 * len + $urandom_range(0, 2);
    n = t + 1;
    if ($urandom_range(0, 3) == 0) begin
      add_ticks(t / 2);
      add_start($urandom, 20'($urandom), 24'($urandom));
      add_ticks(t - t / 2);
      n++;
    end else begin
      add_ticks(t);
    end
  endtask

  // Ticks while idle and starts with a zero field: none may begin a move.
  task automatic add_noise();
    case ($urandom_range(0, 3))
      0: add_start(32'd0, 20'($urandom), 24'($urandom));
      1: add_start($urandom, 20'd0, 24'($urandom));
      2: add_start($urandom, 20'($urandom), 24'd0);
      default: add_ticks(1);
    endcase
  endtask

  task automatic run_phase(input int unsigned quota);
    int unsigned n, made;
    made = 0;
    while (made < quota) begin
      if ($urandom_range(0, 4) == 0) begin
        add_noise();
        made++;
      end else begin
        add_random_move(n);
        made += n;
      end
    end
    drain();
  endtask

  // Input driver: presents the next pending transaction once the last one was taken.
  always @(negedge clk) begin
    motion_cmd_t c;
    if (!in_valid || accept_count == present_count) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && in_valid && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        cmd_mode <= c.mode;
        cmd_steps <= c.steps;
        cmd_speed <= c.speed;
        cmd_accel <= c.accel;
        in_valid <= 1'b1;
        present_count <= present_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts each accepted command and checks each delivered result.
  always @(posedge clk) begin
    motion_cmd_t c;
    pin_state_t r, w;
    if (rst_n && in_valid && !in_stall) begin
      c.mode = cmd_mode;
      c.steps = cmd_steps;
      c.speed = cmd_speed;
      c.accel = cmd_accel;
      advance_ramp(c, r);
      expected_pins.push_back(r);
      accept_count <= accept_count + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pins.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        w = expected_pins.pop_front();
        if (accepted !== w.accepted) report_mismatch("accepted", 32'(accepted), 32'(w.accepted));
        if (direction !== w.direction)
          report_mismatch("direction", 32'(direction), 32'(w.direction));
        if (step_level !== w.step_level)
          report_mismatch("step_level", 32'(step_level), 32'(w.step_level));
        if (reload_period !== w.reload)
          report_mismatch("reload_period", 32'(reload_period), 32'(w.reload));
        if (running !== w.running) report_mismatch("running", 32'(running), 32'(w.running));
        if (move_done !== w.done) report_mismatch("move_done", 32'(move_done), 32'(w.done));
        if (position !== w.position) report_mismatch("position", position, w.position);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: idle tick, rejected starts, speed and acceleration extremes.
    add_ticks(1);
    add_start(32'd0, 20'd100, 24'd100);
    add_start(32'd5, 20'd0, 24'd100);
    add_start(32'd5, 20'd100, 24'd0);
    add_start(32'd3, 20'd1, 24'hFFFFFF);
    add_ticks(2);
    add_start(32'd7, 20'd500, 24'd500);
    add_ticks(5);
    add_start(-32'sd2, 20'hFFFFF, 24'd1);
    add_ticks(5);
    add_start(32'd1, 20'd1000, 24'd1000);
    add_ticks(3);
    drain();

    run_phase(85);
    // Widest window.
    write_reg(CfgMinPeriod, 16'd1);
    write_reg(CfgMaxPeriod, 16'hFFFF);
    run_phase(85);
    // Crossed registers: the upper limit wins.
    write_reg(CfgMinPeriod, 16'hFFFF);
    write_reg(CfgMaxPeriod, 16'd1);
    run_phase(80);
    // Tight cap so braking saturates.
    write_reg(CfgMinPeriod, 16'd100);
    write_reg(CfgMaxPeriod, 16'd200);
    run_phase(80);
    write_reg(CfgMinPeriod, 16'($urandom_range(1, 2000)));
    write_reg(CfgMaxPeriod, 16'($urandom_range(2000, 65535)));
    quiet = 1'b1;
    run_phase(80);

    // Most negative count: the move outlasts the run, so a second start is refused.
    add_start(32'h8000_0000, 20'd2000, 24'd5000);
    add_ticks(12);
    add_start(32'h7FFF_FFFF, 20'd2000, 24'd5000);
    drain();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
